FILE: rtl/mbcd_pkg.sv
// ----------------------------------------------------------------------------
// Motion bitmap change detector package
// Shared item types, picture size codes and per-size packet tables.
// ----------------------------------------------------------------------------
package mbcd_pkg;

	// Default geometry of the stores.
	localparam int MAX_BITMAP_BYTES_DEF = 256;
	localparam int NUM_CHANNELS_DEF     = 4;
	localparam int SIZE_COUNT           = 4;

	// Picture size codes.
	localparam logic [1:0] SIZE_D1   = 2'd0;
	localparam logic [1:0] SIZE_HD1  = 2'd1;
	localparam logic [1:0] SIZE_CIF  = 2'd2;
	localparam logic [1:0] SIZE_QCIF = 2'd3;

	// Item mode.
	typedef enum logic [0:0] {
		MODE_MASK   = 1'b0,
		MODE_MOTION = 1'b1
	} mode_t;

	// Input item.
	typedef struct packed {
		mode_t      mode;
		logic [1:0] channel;
		logic [1:0] size_code;
		logic [7:0] byte_index;
		logic [7:0] data_byte;
	} mbcd_in_t;

	// Result item.
	typedef struct packed {
		logic [1:0] out_channel;
		logic       motion_found;
	} mbcd_out_t;

	// Control of a motion byte in the evaluation stage.
	typedef struct packed {
		logic       last;
		logic [7:0] keep;
	} mbcd_ctl_t;

	// Packet length in bytes for each picture size.
	function automatic logic [7:0] pkt_len(input logic [1:0] size);
		logic [7:0] len;
		unique case (size)
			SIZE_D1:   len = 8'd203;
			SIZE_HD1:  len = 8'd102;
			SIZE_CIF:  len = 8'd50;
			SIZE_QCIF: len = 8'd13;
			default:   len = 8'd13;
		endcase
		return len;
	endfunction

	// Bits of the last byte that carry macroblocks; the unused low bits are zero.
	function automatic logic [7:0] last_keep(input logic [1:0] size);
		logic [2:0] spare;
		unique case (size)
			SIZE_D1:   spare = 3'd4;
			SIZE_HD1:  spare = 3'd6;
			SIZE_CIF:  spare = 3'd4;
			SIZE_QCIF: spare = 3'd5;
			default:   spare = 3'd5;
		endcase
		return 8'hFF << spare;
	endfunction

endpackage

FILE: rtl/motion_bitmap_change_detector_top.sv
// ----------------------------------------------------------------------------
// Motion bitmap change detector
// Region-of-interest motion test over an encoder's macroblock motion bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_stall, item) takes one byte per item:
//   a mask byte write or a motion bitmap byte. Bytes past the packet length
//   of the picture size are dropped. The result channel (result_valid,
//   result_stall, result) gives the channel and the motion flag once for
//   every motion byte at the last index of its packet.
//   Throughput is one item per cycle while item_stall is low; the limit is
//   the single read and single write of the previous-byte RAM per cycle,
//   with the write of one byte forwarded to the read of the next. A result
//   passes the evaluation stage and the result register after the last
//   byte of its packet is accepted. After reset both stores are cleared by
//   a sweep over all NUM_CHANNELS * 4 * MAX_BITMAP_BYTES mask addresses
//   (4096 by default); item_stall is high during the sweep.
//   While result_stall holds a waiting result, items keep flowing until a
//   second last byte reaches the evaluation stage; that stage then holds
//   and item_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module motion_bitmap_change_detector_top #(
	parameter int MAX_BITMAP_BYTES = mbcd_pkg::MAX_BITMAP_BYTES_DEF,
	parameter int NUM_CHANNELS     = mbcd_pkg::NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mbcd_pkg::mbcd_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output mbcd_pkg::mbcd_out_t result
);

	import mbcd_pkg::*;

	localparam int MASK_DEPTH = NUM_CHANNELS * SIZE_COUNT * MAX_BITMAP_BYTES;
	localparam int MAW        = $clog2(MASK_DEPTH);
	localparam int PAW        = $clog2(MAX_BITMAP_BYTES);

	// Clearing sweep.
	logic           clr_busy;
	logic [MAW-1:0] clr_addr;

	// Decode of the presented item.
	logic           accept;
	logic [1:0]     chan_sat;
	logic [7:0]     len;
	logic           in_range;
	logic           is_last;
	logic [3:0]     mask_row;
	logic [MAW-1:0] mask_addr;
	logic [PAW-1:0] prev_addr;
	logic           motion_rd;
	logic           fwd_hit;

	// Evaluation stage.
	logic           valid_s1;
	mbcd_ctl_t      ctl_s1;
	logic [1:0]     chan_s1;
	logic [PAW-1:0] idx_s1;
	logic [7:0]     data_s1;
	logic           fwd_s1;
	logic [7:0]     fwd_data_s1;
	logic           hold;
	logic           fire;
	logic           changed;
	logic           prev_wr;

	// Memory ports.
	logic           mask_we;
	logic [MAW-1:0] mask_waddr;
	logic [7:0]     mask_wdata;
	logic [7:0]     mask_rdata;
	logic           prev_we;
	logic [PAW-1:0] prev_waddr;
	logic [7:0]     prev_wdata;
	logic [7:0]     prev_rdata;
	logic [7:0]     prev_byte;

	mbcd_clear #(
		.DEPTH (MASK_DEPTH)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// Item decode: channel saturation, packet bounds and store addresses.
	always_comb begin
		chan_sat  = (32'(item.channel) >= NUM_CHANNELS) ?
			2'(NUM_CHANNELS - 1) : item.channel;
		len       = pkt_len(item.size_code);
		in_range  = (item.byte_index < len) &&
			(32'(item.byte_index) < MAX_BITMAP_BYTES);
		is_last   = ((9'(item.byte_index) + 9'd1) == 9'(len));
		mask_row  = {chan_sat, item.size_code};
		mask_addr = MAW'(32'(mask_row) * 32'(MAX_BITMAP_BYTES)) + MAW'(item.byte_index);
		prev_addr = PAW'(item.byte_index);
	end

	// The evaluation stage holds while its result cannot leave.
	assign hold       = valid_s1 && ctl_s1.last && result_valid && result_stall;
	assign fire       = valid_s1 && !hold;
	assign item_stall = clr_busy || hold;
	assign accept     = item_valid && !item_stall;
	assign motion_rd  = accept && in_range && (item.mode == MODE_MOTION);
	assign prev_wr    = fire && changed;

	// A write-back in this cycle to the byte being read is forwarded.
	assign fwd_hit = prev_wr && (idx_s1 == prev_addr);

	// Mask store: written by mask items or the sweep, read by motion items.
	assign mask_we    = clr_busy || (accept && in_range && (item.mode == MODE_MASK));
	assign mask_waddr = clr_busy ? clr_addr : mask_addr;
	assign mask_wdata = clr_busy ? 8'd0 : item.data_byte;

	mbcd_ram #(
		.WIDTH (8),
		.DEPTH (MASK_DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.re    (motion_rd),
		.raddr (mask_addr),
		.rdata (mask_rdata)
	);

	// Previous-byte store: written back by the evaluation stage or the sweep.
	assign prev_we    = (clr_busy && (clr_addr < MAW'(MAX_BITMAP_BYTES))) || prev_wr;
	assign prev_waddr = clr_busy ? PAW'(clr_addr) : idx_s1;
	assign prev_wdata = clr_busy ? 8'd0 : data_s1;

	mbcd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BITMAP_BYTES)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (motion_rd),
		.raddr (prev_addr),
		.rdata (prev_rdata)
	);

	// Evaluation stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= in_range && (item.mode == MODE_MOTION);
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Evaluation stage payload.
	always_ff @(posedge clk) begin
		if (motion_rd) begin
			ctl_s1.last <= is_last;
			ctl_s1.keep <= is_last ? last_keep(item.size_code) : 8'hFF;
			chan_s1     <= chan_sat;
			idx_s1      <= prev_addr;
			data_s1     <= item.data_byte;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= data_s1;
		end
	end

	assign prev_byte = fwd_s1 ? fwd_data_s1 : prev_rdata;

	mbcd_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.ctl          (ctl_s1),
		.chan         (chan_s1),
		.data         (data_s1),
		.prev         (prev_byte),
		.mask         (mask_rdata),
		.changed      (changed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// No result can appear while the stores are being cleared.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !result_valid)
		else $error("result presented during clearing sweep");

	// The evaluation stage never writes back during the sweep.
	a_no_writeback_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !valid_s1)
		else $error("evaluation stage active during clearing sweep");

	// A held evaluation stage keeps its item.
	a_hold_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_stall && !clr_busy) |=> valid_s1)
		else $error("held item lost from evaluation stage");
`endif

endmodule

FILE: rtl/mbcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module mbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mbcd_clear.sv
// ----------------------------------------------------------------------------
// Store clearing sequencer
// Sweeps every address once after reset so the stores read as zero.
// ----------------------------------------------------------------------------
module mbcd_clear #(
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     busy,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int AW = $clog2(DEPTH);

	logic          busy_q;
	logic [AW-1:0] cnt_q;

	// One address per cycle until the last one has been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

FILE: rtl/mbcd_result.sv
// ----------------------------------------------------------------------------
// Change evaluation and result register
// Compares a motion byte with its previous byte, gathers motion and holds
// the result item for the receiver.
// ----------------------------------------------------------------------------
module mbcd_result (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  mbcd_pkg::mbcd_ctl_t   ctl,
	input  logic [1:0]            chan,
	input  logic [7:0]            data,
	input  logic [7:0]            prev,
	input  logic [7:0]            mask,
	output logic                  changed,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mbcd_pkg::mbcd_out_t   result
);

	import mbcd_pkg::*;

	logic      hit;
	logic      emit;
	logic      acc_q;
	logic      result_valid_q;
	mbcd_out_t result_q;

	// Only the kept bits take part in the compare and the mask test.
	assign changed = (((prev ^ data) & ctl.keep) != 8'd0);
	assign hit     = changed && ((mask & data & ctl.keep) != 8'd0);
	assign emit    = fire && ctl.last;

	// Motion gathered since the previous result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (emit) begin
			acc_q <= 1'b0;
		end else if (fire && hit) begin
			acc_q <= 1'b1;
		end
	end

	// Result register; the stage upstream holds a last byte while it is full and stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.out_channel  <= chan;
			result_q.motion_found <= acc_q || hit;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: sim/motion_report_checker.sv
// ----------------------------------------------------------------------------
// Motion report checker
// Watches both channels of the change detector. It keeps its own copy of the
// mask and previous-byte stores, predicts a report for every motion byte at
// the last index of a packet, and compares each report that leaves the block
// with the oldest one still due.
// ----------------------------------------------------------------------------
module motion_report_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  mbcd_pkg::mbcd_in_t  item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  mbcd_pkg::mbcd_out_t result,
	output int                  errors,
	output int                  reports_due,
	output int                  reports_seen,
	output int                  motion_reports
);
	import mbcd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [7:0] roi_mask [NUM_CHANNELS_DEF][SIZE_COUNT][MAX_BITMAP_BYTES_DEF];
	logic [7:0] last_bitmap [MAX_BITMAP_BYTES_DEF];
	logic       motion_seen;
	mbcd_out_t  due_reports [$];

	// Number of bytes in one packet of the given picture size.
	function automatic int frame_bytes(input logic [1:0] sz);
		int n;
		case (sz)
			SIZE_D1:  n = 203;
			SIZE_HD1: n = 102;
			SIZE_CIF: n = 50;
			default:  n = 13;
		endcase
		return n;
	endfunction

	// Number of low bits of the last byte that carry no macroblock.
	function automatic int tail_spare(input logic [1:0] sz);
		int n;
		case (sz)
			SIZE_D1:  n = 4;
			SIZE_HD1: n = 6;
			SIZE_CIF: n = 4;
			default:  n = 5;
		endcase
		return n;
	endfunction

	// Counts a failure and prints the first few of them.
	task automatic flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// Applies one accepted item to the predicted stores and queues a report
	// when it is the last byte of a packet.
	task automatic absorb_byte(input mbcd_in_t it);
		int         len;
		logic [1:0] ch;
		logic [7:0] keep;
		logic [7:0] roi;
		logic [7:0] prev;
		mbcd_out_t  report;
		len = frame_bytes(it.size_code);
		ch  = it.channel;
		if (32'(ch) >= NUM_CHANNELS_DEF)
			ch = 2'(NUM_CHANNELS_DEF - 1);
		// Bytes beyond the packet are dropped without a trace.
		if (int'(it.byte_index) >= len || int'(it.byte_index) >= MAX_BITMAP_BYTES_DEF)
			return;
		if (it.mode == MODE_MASK) begin
			roi_mask[ch][it.size_code][it.byte_index] = it.data_byte;
			return;
		end
		// The last byte only counts the bits above its unused low bits.
		keep = 8'hFF;
		if (int'(it.byte_index) == len - 1)
			keep = 8'hFF << tail_spare(it.size_code);
		roi  = roi_mask[ch][it.size_code][it.byte_index];
		prev = last_bitmap[it.byte_index];
		if ((prev & keep) != (it.data_byte & keep)) begin
			last_bitmap[it.byte_index] = it.data_byte;
			if ((roi & it.data_byte & keep) != 8'h00)
				motion_seen = 1'b1;
		end
		if (int'(it.byte_index) == len - 1) begin
			report.out_channel  = ch;
			report.motion_found = motion_seen;
			due_reports.push_back(report);
			motion_seen = 1'b0;
		end
	endtask

	// Compares one report from the block with the oldest one due.
	task automatic compare_report(input mbcd_out_t got);
		mbcd_out_t want;
		reports_seen++;
		if (got.motion_found === 1'b1)
			motion_reports++;
		if (due_reports.size() == 0) begin
			flag_error($sformatf("report ch=%0d motion=%0b with none due",
				got.out_channel, got.motion_found));
			return;
		end
		want = due_reports.pop_front();
		if (got.out_channel !== want.out_channel || got.motion_found !== want.motion_found)
			flag_error($sformatf("expected ch=%0d motion=%0b, got ch=%0d motion=%0b",
				want.out_channel, want.motion_found, got.out_channel, got.motion_found));
	endtask

	// Both channels are sampled at the rising edge; reports are checked
	// before the same edge's item can queue a new one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS_DEF; c++)
				for (int s = 0; s < SIZE_COUNT; s++)
					for (int b = 0; b < MAX_BITMAP_BYTES_DEF; b++)
						roi_mask[c][s][b] = 8'h00;
			for (int b = 0; b < MAX_BITMAP_BYTES_DEF; b++)
				last_bitmap[b] = 8'h00;
			motion_seen = 1'b0;
			due_reports.delete();
			errors         = 0;
			reports_seen   = 0;
			motion_reports = 0;
			reports_due    = 0;
		end else begin
			if (result_valid && !result_stall)
				compare_report(result);
			if (item_valid && !item_stall)
				absorb_byte(item);
			reports_due = due_reports.size();
		end
	end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Motion bitmap change detector testbench
// Drives mask writes, motion packets and noise into the block with random
// gaps on both channels, and leaves prediction and comparison to the
// motion report checker.
// ----------------------------------------------------------------------------
module tb;
	import mbcd_pkg::*;

	localparam int BYTE_TARGET    = 750;
	localparam int IDLE_PERCENT   = 18;
	localparam int CALM_FROM      = 300;
	localparam int CALM_TO        = 420;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 8;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	mbcd_in_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	mbcd_out_t result;

	logic      calm           = 1'b0;
	int        bytes_in_range = 0;
	int        quiet_cycles   = 0;
	int        errors;
	int        reports_due;
	int        reports_seen;
	int        motion_reports;
	logic [7:0] sent_bitmap [MAX_BITMAP_BYTES_DEF];

	always #5 clk = ~clk;

	motion_bitmap_change_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	motion_report_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.errors         (errors),
		.reports_due    (reports_due),
		.reports_seen   (reports_seen),
		.motion_reports (motion_reports)
	);

	// The report side stalls at random, except during the calm stretch.
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles.", quiet_cycles);
			$display("FAIL motion_bitmap_change_detector_top");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic mbcd_in_t byte_item(input mode_t md, input logic [1:0] ch,
		input logic [1:0] sz, input logic [7:0] idx, input logic [7:0] data);
		mbcd_in_t it;
		it.mode       = md;
		it.channel    = ch;
		it.size_code  = sz;
		it.byte_index = idx;
		it.data_byte  = data;
		return it;
	endfunction

	// Mostly the short picture sizes, the full D1 packet only now and then.
	function automatic logic [1:0] pick_size();
		int r;
		logic [1:0] sz;
		r = $urandom_range(99);
		if (r < 50)
			sz = SIZE_QCIF;
		else if (r < 80)
			sz = SIZE_CIF;
		else if (r < 95)
			sz = SIZE_HD1;
		else
			sz = SIZE_D1;
		return sz;
	endfunction

	// Presents one item after an optional gap and waits until it is taken.
	// Called and left at a falling edge.
	task automatic send_byte(input mbcd_in_t it);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < IDLE_PERCENT)
				gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (it.byte_index < pkt_len(it.size_code))
			bytes_in_range++;
		calm = (bytes_in_range >= CALM_FROM && bytes_in_range < CALM_TO);
		@(negedge clk);
	endtask

	// A run of mask writes for one channel and size, now and then a full packet.
	task automatic send_masks(input logic [1:0] sz, input logic [1:0] ch);
		int         len;
		int         count;
		int         start;
		int         idx;
		logic [7:0] data;
		len   = int'(pkt_len(sz));
		count = ($urandom_range(9) == 0) ? len : $urandom_range(1, 16);
		start = $urandom_range(len - 1);
		for (int k = 0; k < count; k++) begin
			idx  = (start + k) % len;
			data = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
			send_byte(byte_item(MODE_MASK, ch, sz, idx[7:0], data));
		end
	endtask

	// One motion packet in order; a few start mid-packet or drop a byte.
	task automatic send_packet(input logic [1:0] sz, input logic [1:0] ch);
		int         len;
		int         start;
		int         pick;
		logic [7:0] data;
		len   = int'(pkt_len(sz));
		start = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : 0;
		for (int i = start; i < len; i++) begin
			pick = $urandom_range(9);
			if (pick < 4)
				data = sent_bitmap[i];
			else if (pick == 4)
				data = 8'h00;
			else if (pick == 5)
				data = 8'hFF;
			else
				data = 8'($urandom);
			if (i == len - 1 || $urandom_range(19) != 0) begin
				send_byte(byte_item(MODE_MOTION, ch, sz, i[7:0], data));
				sent_bitmap[i] = data;
			end
		end
	endtask

	initial begin
		int pick;
		for (int i = 0; i < MAX_BITMAP_BYTES_DEF; i++)
			sent_bitmap[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Masked motion on a QCIF packet, then a last byte that differs only
		// in its unused low bits, a clean last byte and a changed last byte.
		send_byte(byte_item(MODE_MASK,   2'd0, SIZE_QCIF, 8'd12, 8'hFF));
		send_byte(byte_item(MODE_MASK,   2'd0, SIZE_QCIF, 8'd0,  8'hFF));
		send_byte(byte_item(MODE_MOTION, 2'd0, SIZE_QCIF, 8'd0,  8'hFF));
		send_byte(byte_item(MODE_MOTION, 2'd0, SIZE_QCIF, 8'd12, 8'h07));
		send_byte(byte_item(MODE_MOTION, 2'd0, SIZE_QCIF, 8'd12, 8'h00));
		send_byte(byte_item(MODE_MOTION, 2'd0, SIZE_QCIF, 8'd12, 8'hF8));
		// Items past the packet length in both modes.
		send_byte(byte_item(MODE_MOTION, 2'd0, SIZE_QCIF, 8'd13,  8'hFF));
		send_byte(byte_item(MODE_MASK,   2'd3, SIZE_D1,   8'd255, 8'hFF));
		send_byte(byte_item(MODE_MOTION, 2'd3, SIZE_D1,   8'd255, 8'hFF));
		// Last byte of a D1 packet on the highest channel.
		send_byte(byte_item(MODE_MASK,   2'd3, SIZE_D1,   8'd202, 8'hA5));
		send_byte(byte_item(MODE_MOTION, 2'd3, SIZE_D1,   8'd202, 8'hF0));
		// The previous-byte store is shared across channels and sizes.
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_CIF,  8'd0,   8'h00));
		send_byte(byte_item(MODE_MOTION, 2'd1, SIZE_HD1,  8'd101, 8'hFF));
		send_byte(byte_item(MODE_MASK,   2'd1, SIZE_HD1,  8'd101, 8'h40));
		send_byte(byte_item(MODE_MOTION, 2'd1, SIZE_HD1,  8'd101, 8'h40));
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_CIF,  8'd49,  8'h0F));
		// Bytes out of order, high indexes, then a last byte.
		send_byte(byte_item(MODE_MASK,   2'd2, SIZE_D1,   8'd128, 8'h80));
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_D1,   8'd128, 8'h80));
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_D1,   8'd5,   8'h55));
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_D1,   8'd3,   8'hAA));
		send_byte(byte_item(MODE_MOTION, 2'd2, SIZE_D1,   8'd202, 8'h0F));

		// Random part: mask runs, well-formed packets and raw noise.
		while (bytes_in_range < BYTE_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 20)
				send_masks(pick_size(), 2'($urandom));
			else if (pick < 85)
				send_packet(pick_size(), 2'($urandom));
			else
				send_byte(byte_item(mode_t'($urandom_range(1)), 2'($urandom),
					2'($urandom), 8'($urandom), 8'($urandom)));
		end
		item_valid <= 1'b0;

		// Drain the remaining reports, then let the block run on idle.
		do @(negedge clk); while (reports_due != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d in-range bytes; %0d packet reports checked, %0d with motion.",
			bytes_in_range, reports_seen, motion_reports);
		$display("Mismatches: %0d, reports still due: %0d.", errors, reports_due);
		if (errors == 0 && reports_due == 0)
			$display("PASS motion_bitmap_change_detector_top");
		else
			$display("FAIL motion_bitmap_change_detector_top");
		$finish;
	end

endmodule
